// File: rtl/tps_pkg.sv
// Shared constants and types for the triangle projection and shading block.
`timescale 1ns / 1ps

package tps_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int SCREEN_HALF  = 64;
    localparam int SCREEN_SHIFT = $clog2(SCREEN_HALF);
    localparam int SHADE_BIAS   = 154;
    localparam int SHADE_FULL   = 256;
    localparam int EDGE_BITS    = 14;

    localparam int DIV_QBITS = 29;
    localparam int DIV_NBITS = 63;
    localparam int DIV_DBITS = 46;

    localparam int SQRT_BITS  = 60;
    localparam int SQRT_STEPS = SQRT_BITS / 2;

    localparam int     DEPTH_SCALE = 9999;
    localparam longint DEPTH_BASE  = (longint'(10000) << FRAC_BITS) / 9999;
    localparam longint DEPTH_ZERO  = -((longint'(1000) << FRAC_BITS) / 9999);
    localparam longint DEPTH_NUM   = longint'(1000) << (2 * FRAC_BITS);

    localparam int LANE_LAT  = 33;
    localparam int SHADE_LAT = 70;
    localparam int ALIGN_LAT = SHADE_LAT - LANE_LAT;

    localparam int PADDR_BITS = 3;

    typedef enum logic {
        REG_FOCAL = 1'b0,
        REG_CAMZ  = 1'b1
    } tps_reg_t;

    typedef struct packed {
        logic neg;
        logic flag;
    } tps_tag_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } tps_vert_t;

    typedef struct packed {
        tps_vert_t a;
        tps_vert_t b;
        tps_vert_t c;
    } tps_tri_t;

    typedef struct packed {
        logic signed [5:0] color;
        logic              last;
    } tps_side_t;

endpackage

// File: rtl/triangle_project_shade_core.sv
// Top level of the triangle projection and flat shading block.
`timescale 1ns / 1ps

// A request is one triangle: three Q16.16 vertices, a color index and a last flag.
// It is taken at a rising edge where start is high and busy is low; busy stays low,
// so a new request may be issued in every cycle.
// Each request yields one result on the output ports, marked by done for exactly one
// cycle. Results come back in order. Three vertex lanes project the vertices side by
// side while the shading unit computes the brightness; a merge stage aligns both and
// registers the result. The latency is set by the shading path: a 30-stage square
// root followed by a 29-stage divider, one bit per stage. Throughput is one triangle
// per cycle. The receiver cannot stall; results must be taken in the cycle they
// appear. focal_scale (address 0) and camera_z (address 4) are written through the
// APB port; the user must write them only while no request is in flight, and the
// block itself does not enforce it. Reset clears the pipeline valid bits, returns
// focal_scale to 1.0 and camera_z to 0; no clearing pass is needed.
module triangle_project_shade_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [31:0]                ax_in,
    input  logic signed [31:0]                ay_in,
    input  logic signed [31:0]                az_in,
    input  logic signed [31:0]                bx_in,
    input  logic signed [31:0]                by_in,
    input  logic signed [31:0]                bz_in,
    input  logic signed [31:0]                cx_in,
    input  logic signed [31:0]                cy_in,
    input  logic signed [31:0]                cz_in,
    input  logic signed [5:0]                 color_in,
    input  logic                              last_in,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tps_pkg::PADDR_BITS-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output logic                              done,
    output logic signed [31:0]                ax_out,
    output logic signed [31:0]                ay_out,
    output logic signed [31:0]                az_out,
    output logic signed [31:0]                bx_out,
    output logic signed [31:0]                by_out,
    output logic signed [31:0]                bz_out,
    output logic signed [31:0]                cx_out,
    output logic signed [31:0]                cy_out,
    output logic signed [31:0]                cz_out,
    output logic [8:0]                        shade,
    output logic signed [5:0]                 color_out,
    output logic                              last_out
);
    import tps_pkg::*;

    logic [30:0]          focal_scale_reg, focal_scale_next;
    logic signed [31:0]   camera_z_reg, camera_z_next;
    logic                 cfg_wr;
    logic                 accept;

    logic [SHADE_LAT-1:0] valid_reg, valid_next;
    tps_side_t            side_reg  [0:SHADE_LAT-1];
    tps_side_t            side_next [0:SHADE_LAT-1];
    tps_tri_t             align_reg  [0:ALIGN_LAT-1];
    tps_tri_t             align_next [0:ALIGN_LAT-1];

    tps_vert_t            vin  [0:2];
    tps_vert_t            vout [0:2];
    logic [8:0]           shade_w;

    logic                 done_reg, done_next;
    tps_tri_t             tri_reg, tri_next;
    logic [8:0]           shade_reg, shade_next;
    tps_side_t            oside_reg, oside_next;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        focal_scale_next = focal_scale_reg;
        camera_z_next    = camera_z_reg;
        if (cfg_wr)
        begin
            case (tps_reg_t'(paddr[2]))
                REG_FOCAL: focal_scale_next = pwdata[30:0];
                REG_CAMZ:  camera_z_next    = $signed(pwdata);
                default:   focal_scale_next = focal_scale_reg;
            endcase
        end
    end

    always_comb
    begin
        case (tps_reg_t'(paddr[2]))
            REG_FOCAL: prdata = {1'b0, focal_scale_reg};
            REG_CAMZ:  prdata = camera_z_reg;
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_scale_reg <= 31'(1 << FRAC_BITS);
            camera_z_reg    <= '0;
            valid_reg       <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            focal_scale_reg <= focal_scale_next;
            camera_z_reg    <= camera_z_next;
            valid_reg       <= valid_next;
            done_reg        <= done_next;
        end
    end

    assign vin[0] = '{x: ax_in, y: ay_in, z: az_in};
    assign vin[1] = '{x: bx_in, y: by_in, z: bz_in};
    assign vin[2] = '{x: cx_in, y: cy_in, z: cz_in};

    for (genvar g = 0; g < 3; g++) begin : g_lane
        tps_vertex u_lane (
            .clk   (clk),
            .vin   (vin[g]),
            .focal (focal_scale_reg),
            .camz  (camera_z_reg),
            .vout  (vout[g])
        );
    end

    tps_shade u_shade (
        .clk   (clk),
        .v0    (vin[0]),
        .v1    (vin[1]),
        .v2    (vin[2]),
        .shade (shade_w)
    );

    always_comb
    begin
        valid_next   = {valid_reg[SHADE_LAT-2:0], accept};
        side_next[0] = '{color: color_in, last: last_in};
        for (int i = 1; i < SHADE_LAT; i++)
            side_next[i] = side_reg[i-1];
        align_next[0] = '{a: vout[0], b: vout[1], c: vout[2]};
        for (int i = 1; i < ALIGN_LAT; i++)
            align_next[i] = align_reg[i-1];
        done_next  = valid_reg[SHADE_LAT-1];
        tri_next   = align_reg[ALIGN_LAT-1];
        shade_next = shade_w;
        oside_next = side_reg[SHADE_LAT-1];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SHADE_LAT; i++)
            side_reg[i] <= side_next[i];
        for (int i = 0; i < ALIGN_LAT; i++)
            align_reg[i] <= align_next[i];
        tri_reg   <= tri_next;
        shade_reg <= shade_next;
        oside_reg <= oside_next;
    end

    assign done      = done_reg;
    assign ax_out    = tri_reg.a.x;
    assign ay_out    = tri_reg.a.y;
    assign az_out    = tri_reg.a.z;
    assign bx_out    = tri_reg.b.x;
    assign by_out    = tri_reg.b.y;
    assign bz_out    = tri_reg.b.z;
    assign cx_out    = tri_reg.c.x;
    assign cy_out    = tri_reg.c.y;
    assign cz_out    = tri_reg.c.z;
    assign shade     = shade_reg;
    assign color_out = oside_reg.color;
    assign last_out  = oside_reg.last;

endmodule

// File: rtl/tps_div.sv
// Pipelined restoring divider producing one quotient bit per stage.
`timescale 1ns / 1ps

module tps_div (
    input  logic                            clk,
    input  logic [tps_pkg::DIV_NBITS-1:0]   num,
    input  logic [tps_pkg::DIV_DBITS-1:0]   den,
    input  tps_pkg::tps_tag_t               tag_in,
    output logic [tps_pkg::DIV_QBITS-1:0]   quot,
    output logic                            big,
    output tps_pkg::tps_tag_t               tag_out
);
    import tps_pkg::*;

    logic [DIV_DBITS-1:0] rem_reg  [0:DIV_QBITS];
    logic [DIV_DBITS-1:0] rem_next [0:DIV_QBITS];
    logic [DIV_QBITS-1:0] low_reg  [0:DIV_QBITS];
    logic [DIV_QBITS-1:0] low_next [0:DIV_QBITS];
    logic [DIV_QBITS-1:0] quo_reg  [0:DIV_QBITS];
    logic [DIV_QBITS-1:0] quo_next [0:DIV_QBITS];
    logic [DIV_DBITS-1:0] den_reg  [0:DIV_QBITS];
    logic [DIV_DBITS-1:0] den_next [0:DIV_QBITS];
    logic                 big_reg  [0:DIV_QBITS];
    logic                 big_next [0:DIV_QBITS];
    tps_tag_t             tag_reg  [0:DIV_QBITS];
    tps_tag_t             tag_next [0:DIV_QBITS];

    // The quotient is known to fit when the top numerator bits are below the divisor.
    assign rem_next[0] = DIV_DBITS'(num[DIV_NBITS-1:DIV_QBITS]);
    assign low_next[0] = num[DIV_QBITS-1:0];
    assign quo_next[0] = '0;
    assign den_next[0] = den;
    assign big_next[0] = (DIV_DBITS'(num[DIV_NBITS-1:DIV_QBITS]) >= den);
    assign tag_next[0] = tag_in;

    for (genvar k = 0; k < DIV_QBITS; k++) begin : g_step
        logic [DIV_DBITS:0] trial;
        logic [DIV_DBITS:0] diff;
        logic               ge;

        assign trial = {rem_reg[k], low_reg[k][DIV_QBITS-1]};
        assign diff  = trial - {1'b0, den_reg[k]};
        assign ge    = (trial >= {1'b0, den_reg[k]});

        assign rem_next[k+1] = ge ? diff[DIV_DBITS-1:0] : trial[DIV_DBITS-1:0];
        assign low_next[k+1] = {low_reg[k][DIV_QBITS-2:0], 1'b0};
        assign quo_next[k+1] = {quo_reg[k][DIV_QBITS-2:0], ge};
        assign den_next[k+1] = den_reg[k];
        assign big_next[k+1] = big_reg[k];
        assign tag_next[k+1] = tag_reg[k];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= DIV_QBITS; i++)
        begin
            rem_reg[i] <= rem_next[i];
            low_reg[i] <= low_next[i];
            quo_reg[i] <= quo_next[i];
            den_reg[i] <= den_next[i];
            big_reg[i] <= big_next[i];
            tag_reg[i] <= tag_next[i];
        end
    end

    assign quot    = quo_reg[DIV_QBITS];
    assign big     = big_reg[DIV_QBITS];
    assign tag_out = tag_reg[DIV_QBITS];

endmodule

// File: rtl/tps_isqrt.sv
// Pipelined integer square root, two radicand bits per stage.
`timescale 1ns / 1ps

module tps_isqrt (
    input  logic                               clk,
    input  logic [tps_pkg::SQRT_BITS-1:0]      val,
    input  logic signed [30:0]                 side_in,
    output logic [tps_pkg::SQRT_STEPS-1:0]     root,
    output logic signed [30:0]                 side_out
);
    import tps_pkg::*;

    logic [SQRT_BITS-1:0] v_reg     [0:SQRT_STEPS];
    logic [SQRT_BITS-1:0] v_next    [0:SQRT_STEPS];
    logic [SQRT_BITS-1:0] r_reg     [0:SQRT_STEPS];
    logic [SQRT_BITS-1:0] r_next    [0:SQRT_STEPS];
    logic signed [30:0]   side_reg  [0:SQRT_STEPS];
    logic signed [30:0]   side_next [0:SQRT_STEPS];

    assign v_next[0]    = val;
    assign r_next[0]    = '0;
    assign side_next[0] = side_in;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        logic [SQRT_BITS-1:0] bit_w;
        logic [SQRT_BITS-1:0] trial;
        logic                 ge;

        assign bit_w = SQRT_BITS'(1) << (SQRT_BITS - 2 - 2 * k);
        assign trial = r_reg[k] + bit_w;
        assign ge    = (v_reg[k] >= trial);

        assign v_next[k+1]    = ge ? (v_reg[k] - trial) : v_reg[k];
        assign r_next[k+1]    = ge ? ((r_reg[k] >> 1) + bit_w) : (r_reg[k] >> 1);
        assign side_next[k+1] = side_reg[k];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= SQRT_STEPS; i++)
        begin
            v_reg[i]    <= v_next[i];
            r_reg[i]    <= r_next[i];
            side_reg[i] <= side_next[i];
        end
    end

    assign root     = r_reg[SQRT_STEPS][SQRT_STEPS-1:0];
    assign side_out = side_reg[SQRT_STEPS];

endmodule

// File: rtl/tps_vertex.sv
// Projection lane for one vertex: focal scaling, perspective divide, screen map and depth map.
`timescale 1ns / 1ps

module tps_vertex (
    input  logic                     clk,
    input  tps_pkg::tps_vert_t       vin,
    input  logic [30:0]              focal,
    input  logic signed [31:0]       camz,
    output tps_pkg::tps_vert_t       vout
);
    import tps_pkg::*;

    localparam int SW = DIV_QBITS + 3 + SCREEN_SHIFT;

    logic signed [32:0]   pz_reg, pz_next;
    logic signed [62:0]   mx_reg, mx_next;
    logic signed [62:0]   my_reg, my_next;
    logic signed [63:0]   mx_full, my_full;

    logic [DIV_NBITS-1:0] nx_reg, nx_next;
    logic [DIV_NBITS-1:0] ny_reg, ny_next;
    logic [DIV_DBITS-1:0] dxy_reg, dxy_next;
    logic [DIV_DBITS-1:0] dz_reg, dz_next;
    tps_tag_t             tx_reg, tx_next;
    tps_tag_t             ty_reg, ty_next;
    tps_tag_t             tz_reg, tz_next;
    logic [32:0]          apz;
    logic                 pzero;

    logic [DIV_QBITS-1:0] qx, qy, qz;
    logic                 bx, by, bz;
    tps_tag_t             ox, oy, oz;

    tps_vert_t            res_reg, res_next;

    function automatic logic signed [31:0] screen_map(input logic [DIV_QBITS-1:0] q,
                                                      input logic big_q,
                                                      input logic neg);
        logic signed [DIV_QBITS:0] t;
        logic signed [SW-1:0]      v;
        logic signed [31:0]        r;
        t = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        v = (SW'(t) + SW'(1 << FRAC_BITS)) <<< SCREEN_SHIFT;
        if (big_q)
            r = neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else if (v[SW-1:31] != {(SW-31){v[SW-1]}})
            r = v[SW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] depth_map(input logic [DIV_QBITS-1:0] q,
                                                     input tps_tag_t tag);
        logic signed [31:0] r;
        if (tag.flag)
            r = 32'(DEPTH_ZERO);
        else if (tag.neg)
            r = 32'(DEPTH_BASE) + 32'(q);
        else
            r = 32'(DEPTH_BASE) - 32'(q);
        return r;
    endfunction

    assign mx_full = vin.x * $signed({1'b0, focal});
    assign my_full = vin.y * $signed({1'b0, focal});

    always_comb
    begin
        pz_next = {vin.z[31], vin.z} - {camz[31], camz};
        mx_next = $signed(mx_full[62:0]);
        my_next = $signed(my_full[62:0]);
    end

    always_comb
    begin
        pzero    = (pz_reg == '0);
        apz      = pz_reg[32] ? 33'(-pz_reg) : 33'(pz_reg);
        nx_next  = mx_reg[62] ? 63'(-mx_reg) : 63'(mx_reg);
        ny_next  = my_reg[62] ? 63'(-my_reg) : 63'(my_reg);
        dxy_next = pzero ? DIV_DBITS'(1 << FRAC_BITS) : DIV_DBITS'(apz);
        dz_next  = DIV_DBITS'(apz) * DIV_DBITS'(DEPTH_SCALE);
        tx_next  = '{neg: mx_reg[62] ^ pz_reg[32], flag: 1'b0};
        ty_next  = '{neg: my_reg[62] ^ pz_reg[32], flag: 1'b0};
        tz_next  = '{neg: pz_reg[32], flag: pzero};
    end

    always_ff @(posedge clk)
    begin
        pz_reg  <= pz_next;
        mx_reg  <= mx_next;
        my_reg  <= my_next;
        nx_reg  <= nx_next;
        ny_reg  <= ny_next;
        dxy_reg <= dxy_next;
        dz_reg  <= dz_next;
        tx_reg  <= tx_next;
        ty_reg  <= ty_next;
        tz_reg  <= tz_next;
        res_reg <= res_next;
    end

    tps_div u_div_x (
        .clk     (clk),
        .num     (nx_reg),
        .den     (dxy_reg),
        .tag_in  (tx_reg),
        .quot    (qx),
        .big     (bx),
        .tag_out (ox)
    );

    tps_div u_div_y (
        .clk     (clk),
        .num     (ny_reg),
        .den     (dxy_reg),
        .tag_in  (ty_reg),
        .quot    (qy),
        .big     (by),
        .tag_out (oy)
    );

    tps_div u_div_z (
        .clk     (clk),
        .num     (DIV_NBITS'(DEPTH_NUM)),
        .den     (dz_reg),
        .tag_in  (tz_reg),
        .quot    (qz),
        .big     (bz),
        .tag_out (oz)
    );

    // The depth quotient overflows only for a zero depth, which the zero flag covers, so its range flag is not needed.
    always_comb
    begin
        res_next.x = screen_map(qx, bx, ox.neg);
        res_next.y = screen_map(qy, by, oy.neg);
        res_next.z = bz ? depth_map(qz, oz) : depth_map(qz, oz);
    end

    assign vout = res_reg;

endmodule

// File: rtl/tps_shade.sv
// Flat shading: edge normalization, cross product, normal length and brightness.
`timescale 1ns / 1ps

module tps_shade (
    input  logic                 clk,
    input  tps_pkg::tps_vert_t   v0,
    input  tps_pkg::tps_vert_t   v1,
    input  tps_pkg::tps_vert_t   v2,
    output logic [8:0]           shade
);
    import tps_pkg::*;

    logic signed [32:0]          e_reg    [0:5];
    logic signed [32:0]          e_next   [0:5];
    logic [32:0]                 mag_reg  [0:5];
    logic [32:0]                 mag_next [0:5];
    logic                        sgn_reg  [0:5];
    logic                        sgn_next [0:5];
    logic [32:0]                 or_reg, or_next;
    logic signed [EDGE_BITS:0]   es_reg   [0:5];
    logic signed [EDGE_BITS:0]   es_next  [0:5];
    logic [5:0]                  blen;
    logic [5:0]                  sh;
    logic signed [29:0]          p_reg    [0:5];
    logic signed [29:0]          p_next   [0:5];
    logic signed [30:0]          n_reg    [0:2];
    logic signed [30:0]          n_next   [0:2];
    logic signed [61:0]          sq_full  [0:2];
    logic [SQRT_BITS-1:0]        sq_reg   [0:2];
    logic [SQRT_BITS-1:0]        sq_next  [0:2];
    logic signed [30:0]          nz6_reg;
    logic [SQRT_BITS-1:0]        sum_reg, sum_next;
    logic signed [30:0]          nz7_reg;

    logic [SQRT_STEPS-1:0]       root;
    logic signed [30:0]          nz_s;

    logic [DIV_NBITS-1:0]        num8_reg, num8_next;
    logic [DIV_DBITS-1:0]        den8_reg, den8_next;
    tps_tag_t                    tag8_reg, tag8_next;
    logic [30:0]                 anz;

    logic [DIV_QBITS-1:0]        quot;
    logic                        big;
    tps_tag_t                    tag_o;
    logic [10:0]                 val;
    logic [8:0]                  shade_reg, shade_next;

    always_comb
    begin
        e_next[0] = {v1.x[31], v1.x} - {v0.x[31], v0.x};
        e_next[1] = {v1.y[31], v1.y} - {v0.y[31], v0.y};
        e_next[2] = {v1.z[31], v1.z} - {v0.z[31], v0.z};
        e_next[3] = {v2.x[31], v2.x} - {v0.x[31], v0.x};
        e_next[4] = {v2.y[31], v2.y} - {v0.y[31], v0.y};
        e_next[5] = {v2.z[31], v2.z} - {v0.z[31], v0.z};
    end

    always_comb
    begin
        or_next = '0;
        for (int i = 0; i < 6; i++)
        begin
            sgn_next[i] = e_reg[i][32];
            mag_next[i] = e_reg[i][32] ? 33'(-e_reg[i]) : 33'(e_reg[i]);
            or_next     = or_next | mag_next[i];
        end
    end

    // The shift brings the largest edge magnitude below the edge limit.
    always_comb
    begin
        blen = '0;
        for (int b = 0; b < 33; b++)
        begin
            if (or_reg[b])
                blen = 6'(b + 1);
        end
        sh = (blen > 6'(EDGE_BITS)) ? (blen - 6'(EDGE_BITS)) : '0;
        for (int i = 0; i < 6; i++)
        begin
            es_next[i] = sgn_reg[i]
                ? -$signed({1'b0, EDGE_BITS'(mag_reg[i] >> sh)})
                : $signed({1'b0, EDGE_BITS'(mag_reg[i] >> sh)});
        end
    end

    always_comb
    begin
        p_next[0] = es_reg[1] * es_reg[5];
        p_next[1] = es_reg[2] * es_reg[4];
        p_next[2] = es_reg[2] * es_reg[3];
        p_next[3] = es_reg[0] * es_reg[5];
        p_next[4] = es_reg[0] * es_reg[4];
        p_next[5] = es_reg[1] * es_reg[3];
        n_next[0] = 31'(p_reg[0]) - 31'(p_reg[1]);
        n_next[1] = 31'(p_reg[2]) - 31'(p_reg[3]);
        n_next[2] = 31'(p_reg[4]) - 31'(p_reg[5]);
        for (int i = 0; i < 3; i++)
        begin
            sq_full[i] = n_reg[i] * n_reg[i];
            sq_next[i] = sq_full[i][SQRT_BITS-1:0];
        end
        sum_next = sq_reg[0] + sq_reg[1] + sq_reg[2];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 6; i++)
        begin
            e_reg[i]   <= e_next[i];
            mag_reg[i] <= mag_next[i];
            sgn_reg[i] <= sgn_next[i];
            es_reg[i]  <= es_next[i];
            p_reg[i]   <= p_next[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            n_reg[i]  <= n_next[i];
            sq_reg[i] <= sq_next[i];
        end
        or_reg    <= or_next;
        nz6_reg   <= n_reg[2];
        sum_reg   <= sum_next;
        nz7_reg   <= nz6_reg;
        num8_reg  <= num8_next;
        den8_reg  <= den8_next;
        tag8_reg  <= tag8_next;
        shade_reg <= shade_next;
    end

    tps_isqrt u_isqrt (
        .clk      (clk),
        .val      (sum_reg),
        .side_in  (nz7_reg),
        .root     (root),
        .side_out (nz_s)
    );

    always_comb
    begin
        anz       = nz_s[30] ? 31'(-nz_s) : 31'(nz_s);
        num8_next = DIV_NBITS'(anz) << 7;
        den8_next = (root == '0) ? DIV_DBITS'(1) : DIV_DBITS'(root);
        tag8_next = '{neg: (!nz_s[30]) && (nz_s != '0), flag: (root == '0)};
    end

    tps_div u_div (
        .clk     (clk),
        .num     (num8_reg),
        .den     (den8_reg),
        .tag_in  (tag8_reg),
        .quot    (quot),
        .big     (big),
        .tag_out (tag_o)
    );

    // The normal's z part never exceeds its length, so the quotient stays within 128.
    always_comb
    begin
        val = tag_o.neg ? (11'(SHADE_BIAS) - 11'(quot[8:0]))
                        : (11'(SHADE_BIAS) + 11'(quot[8:0]));
        if (tag_o.flag || big)
            shade_next = 9'(SHADE_BIAS);
        else if (val > 11'(SHADE_FULL))
            shade_next = 9'(SHADE_FULL);
        else
            shade_next = val[8:0];
    end

    assign shade = shade_reg;

endmodule
